/* src/bqlp_pkg.sv */
// Package for the biquad low-pass filter bank: sizes, register and
// coefficient-set codes, beat and history types, and coefficient unpacking.
// No dependencies.
package bqlp_pkg;

  localparam int CHANNELS    = 16;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;

  localparam int CHANNEL_BITS   = 4;
  localparam int COEF_SET_BITS  = 2;
  localparam int CFG_BITS       = 54;
  localparam int CFG_INDEX_BITS = 2;
  localparam int COEF_PACK_BITS = 3 * COEF_BITS;
  localparam int CH_ADDR_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_FAST      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_SLOW      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_VERY_SLOW = 2'd2;

  // Coefficient set selector codes.
  localparam logic [COEF_SET_BITS-1:0] COEF_SET_FAST      = 2'd0;
  localparam logic [COEF_SET_BITS-1:0] COEF_SET_SLOW      = 2'd1;
  localparam logic [COEF_SET_BITS-1:0] COEF_SET_VERY_SLOW = 2'd2;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0]       channel;
    logic [COEF_SET_BITS-1:0]      coef_set;
    logic                          prime;
    logic signed [SAMPLE_BITS-1:0] sample;
  } samp_beat_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0]       out_channel;
    logic signed [SAMPLE_BITS-1:0] filtered;
  } filt_beat_t;

  // One channel's history, one memory word.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [SAMPLE_BITS-1:0] y1;
    logic signed [SAMPLE_BITS-1:0] y2;
  } hist_t;

  localparam int HIST_BITS = $bits(hist_t);

  typedef struct packed {
    logic signed [COEF_BITS-1:0] a2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] b0;
  } coef_t;

  function automatic coef_t coef_unpack(input logic [CFG_BITS-1:0] r);
    logic [COEF_PACK_BITS-1:0] pad;
    pad = COEF_PACK_BITS'(r);
    return coef_t'(pad);
  endfunction

  function automatic logic ch_in_range(input logic [CHANNEL_BITS-1:0] ch);
    return int'(ch) < CHANNELS;
  endfunction

endpackage

/* src/bqlp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bqlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/bqlp_mac.sv */
// Biquad arithmetic: registered products, then sum, rounding and saturation.
// Depends on bqlp_pkg.
module bqlp_mac (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [bqlp_pkg::SAMPLE_BITS-1:0] x,
  input  bqlp_pkg::hist_t                        hist,
  input  bqlp_pkg::coef_t                        coef,
  output logic signed [bqlp_pkg::SAMPLE_BITS-1:0] y
);

  localparam int SB       = bqlp_pkg::SAMPLE_BITS;
  localparam int CB       = bqlp_pkg::COEF_BITS;
  localparam int XS_BITS  = SB + 2;
  localparam int P0_BITS  = XS_BITS + CB;
  localparam int P_BITS   = SB + CB;
  localparam int ACC_BITS = SB + CB + 4;
  localparam int FRAC     = CB - 2;
  localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) <<< (FRAC - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_HI =
    {{(ACC_BITS-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

  logic signed [XS_BITS-1:0]  xsum;
  logic signed [P0_BITS-1:0]  p0;
  logic signed [P_BITS-1:0]   p1;
  logic signed [P_BITS-1:0]   p2;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] quot;

  // The numerator taps share b0, so the inputs are summed before the multiply.
  assign xsum = XS_BITS'(x) + (XS_BITS'(hist.x1) <<< 1) + XS_BITS'(hist.x2);

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= P0_BITS'(xsum * coef.b0);
      p1 <= P_BITS'(hist.y1 * coef.a1);
      p2 <= P_BITS'(hist.y2 * coef.a2);
    end
  end

  // Round half up, then floor by the coefficient fraction bits.
  assign acc  = ACC_BITS'(p0) - ACC_BITS'(p1) - ACC_BITS'(p2) + HALF;
  assign quot = acc >>> FRAC;

  always_comb begin
    if (quot > SAT_HI) begin
      y = SAT_HI[SB-1:0];
    end else if (quot < SAT_LO) begin
      y = SAT_LO[SB-1:0];
    end else begin
      y = quot[SB-1:0];
    end
  end

endmodule

/* src/biquad_lowpass_filter_bank.sv */
// Top level of the multi-channel biquad low-pass filter bank.
// Depends on bqlp_pkg, bqlp_ram and bqlp_mac.
// Pipeline: a sample beat passes through stage 1, stage 2 and the output register.
// Throughput: one beat per cycle while the output is not stalled; a beat for the
// same channel as the beat just before it waits, since that beat's history is
// not written back to the history memory until it leaves stage 2.
// Reset (synchronous, active high) clears the coefficient registers, pipeline
// valids and per-channel valid bits; the history memory itself is not swept.
module biquad_lowpass_filter_bank (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [bqlp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bqlp_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                  samp_valid,
  output logic                                  samp_stall,
  input  bqlp_pkg::samp_beat_t                  samp_data,
  output logic                                  filt_valid,
  input  logic                                  filt_stall,
  output bqlp_pkg::filt_beat_t                  filt_data
);

  localparam int AB = bqlp_pkg::CH_ADDR_BITS;
  localparam int SB = bqlp_pkg::SAMPLE_BITS;

  // Coefficient registers, one per set.
  logic [bqlp_pkg::CFG_BITS-1:0] coef_fast;
  logic [bqlp_pkg::CFG_BITS-1:0] coef_slow;
  logic [bqlp_pkg::CFG_BITS-1:0] coef_very_slow;

  // The whole pipeline moves together whenever the output register can load.
  logic adv;
  logic samp_accept;
  logic [AB-1:0] samp_addr;

  // Stage 1: history read back from memory, products formed.
  logic                 s1_valid;
  bqlp_pkg::samp_beat_t s1_item;
  logic                 s1_in_range;
  logic                 rd_valid;
  logic [AB-1:0]        s1_addr;
  bqlp_pkg::hist_t      ram_hist;
  bqlp_pkg::hist_t      s1_hist;
  bqlp_pkg::coef_t      s1_coef;
  logic [bqlp_pkg::HIST_BITS-1:0] ram_rdata;

  // Stage 2: sum, round, saturate, write back.
  logic                 s2_valid;
  bqlp_pkg::samp_beat_t s2_item;
  logic                 s2_in_range;
  logic signed [SB-1:0] s2_x1;
  logic signed [SB-1:0] s2_y1;
  logic signed [SB-1:0] mac_y;
  logic signed [SB-1:0] s2_y;
  logic [AB-1:0]        s2_addr;

  // Write port and the forwarding copy of the last write.
  logic            ram_we;
  bqlp_pkg::hist_t wr_hist;
  logic            fwd_valid;
  logic [AB-1:0]   fwd_addr;
  bqlp_pkg::hist_t fwd_hist;

  // Per-entry valid bits: an entry never written reads as zero history.
  logic [bqlp_pkg::CHANNELS-1:0] ent_valid;

  // Configuration writes. An index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_fast      <= '0;
      coef_slow      <= '0;
      coef_very_slow <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bqlp_pkg::CFG_COEF_FAST:      coef_fast      <= cfg_data;
        bqlp_pkg::CFG_COEF_SLOW:      coef_slow      <= cfg_data;
        bqlp_pkg::CFG_COEF_VERY_SLOW: coef_very_slow <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign adv = !filt_valid || !filt_stall;

  // A beat for the channel now in stage 1 must wait: its history is not
  // written until that beat leaves stage 2.
  assign samp_stall  = !adv || (s1_valid && (s1_item.channel == samp_data.channel));
  assign samp_accept = samp_valid && !samp_stall;
  assign samp_addr   = AB'(samp_data.channel);

  bqlp_ram #(
    .WIDTH(bqlp_pkg::HIST_BITS),
    .DEPTH(bqlp_pkg::CHANNELS)
  ) u_hist_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s2_addr),
    .wdata(wr_hist),
    .re   (samp_accept),
    .raddr(samp_addr),
    .rdata(ram_rdata)
  );

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= samp_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (samp_accept) begin
      s1_item     <= samp_data;
      s1_in_range <= bqlp_pkg::ch_in_range(samp_data.channel);
      rd_valid    <= bqlp_pkg::ch_in_range(samp_data.channel) && ent_valid[samp_addr];
    end
  end

  assign s1_addr  = AB'(s1_item.channel);
  assign ram_hist = bqlp_pkg::hist_t'(ram_rdata);

  // The memory read missed any write made at the same edge; take it from the
  // forwarding copy instead.
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      s1_hist = fwd_hist;
    end else if (rd_valid) begin
      s1_hist = ram_hist;
    end else begin
      s1_hist = '0;
    end
  end

  // Selector code three picks all-zero coefficients.
  always_comb begin
    case (s1_item.coef_set)
      bqlp_pkg::COEF_SET_FAST:      s1_coef = bqlp_pkg::coef_unpack(coef_fast);
      bqlp_pkg::COEF_SET_SLOW:      s1_coef = bqlp_pkg::coef_unpack(coef_slow);
      bqlp_pkg::COEF_SET_VERY_SLOW: s1_coef = bqlp_pkg::coef_unpack(coef_very_slow);
      default:                      s1_coef = '0;
    endcase
  end

  bqlp_mac u_mac (
    .clk (clk),
    .en  (adv),
    .x   (s1_item.sample),
    .hist(s1_hist),
    .coef(s1_coef),
    .y   (mac_y)
  );

  // Stage 2 registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item     <= s1_item;
      s2_in_range <= s1_in_range;
      s2_x1       <= s1_hist.x1;
      s2_y1       <= s1_hist.y1;
    end
  end

  assign s2_addr = AB'(s2_item.channel);

  // A prime beat or a channel that is not present returns the sample as is.
  assign s2_y = (!s2_in_range || s2_item.prime) ? s2_item.sample : mac_y;

  always_comb begin
    if (s2_item.prime) begin
      wr_hist = '{x1: s2_item.sample, x2: s2_item.sample,
                  y1: s2_item.sample, y2: s2_item.sample};
    end else begin
      wr_hist = '{x1: s2_item.sample, x2: s2_x1, y1: s2_y, y2: s2_y1};
    end
  end

  assign ram_we = adv && s2_valid && s2_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      ent_valid <= '0;
    end else begin
      if (adv) begin
        fwd_valid <= ram_we;
      end
      if (ram_we) begin
        ent_valid[s2_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr <= s2_addr;
      fwd_hist <= wr_hist;
    end
  end

  // Output register: holds a finished beat while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      filt_valid <= 1'b0;
    end else if (adv) begin
      filt_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      filt_data.out_channel <= s2_item.channel;
      filt_data.filtered    <= s2_y;
    end
  end

`ifndef ASSERT_OFF
  a_no_same_channel_overlap: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_valid |-> s1_item.channel != s2_item.channel)
    else $error("same channel in stages one and two");

  a_prime_passes_sample: assert property (@(posedge clk) disable iff (rst)
    adv && s2_valid && s2_item.prime |=> filt_data.filtered == $past(s2_item.sample))
    else $error("prime beat did not return its sample");

  a_stage2_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    filt_valid && filt_stall && s2_valid |=> s2_valid && $stable(s2_item))
    else $error("stage two changed while the output was stalled");

  a_write_only_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> s2_valid && s2_in_range && adv)
    else $error("history write without a valid in-range beat");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the biquad low-pass filter bank: a queue-fed beat driver,
// a clocked monitor with its own fixed-point filter predictor, and a stall watchdog.
// Depends on bqlp_pkg and biquad_lowpass_filter_bank.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bqlp_pkg::*;

  // Selector code with no coefficient set behind it, and the register index with no register.
  localparam logic [COEF_SET_BITS-1:0]  COEF_SET_NONE = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED    = 2'd3;

  localparam int FRAC           = COEF_BITS - 2;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 250;
  localparam int MAX_IDLE       = 6;
  localparam int SETTLE         = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam longint SAMP_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMP_MIN = -SAMP_MAX - 1;
  localparam longint COEF_MAX = (longint'(1) << (COEF_BITS - 1)) - 1;
  localparam longint COEF_MIN = -COEF_MAX - 1;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]       cfg_data  = '0;
  logic                      samp_valid = 1'b0;
  logic                      samp_stall;
  samp_beat_t                samp_data = '0;
  logic                      filt_valid;
  logic                      filt_stall = 1'b0;
  filt_beat_t                filt_data;

  biquad_lowpass_filter_bank i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .samp_valid (samp_valid),
    .samp_stall (samp_stall),
    .samp_data  (samp_data),
    .filt_valid (filt_valid),
    .filt_stall (filt_stall),
    .filt_data  (filt_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample beats still to be offered, and filtered beats the block still owes.
  samp_beat_t pending_samp [$];
  filt_beat_t pending_filt [$];

  // Local copy of the coefficient registers and of every channel's history.
  logic [CFG_BITS-1:0] coef_bank [3] = '{default: '0};
  longint x_hist1 [CHANNELS] = '{default: 0};
  longint x_hist2 [CHANNELS] = '{default: 0};
  longint y_hist1 [CHANNELS] = '{default: 0};
  longint y_hist2 [CHANNELS] = '{default: 0};

  // Handshake results of the last rising edge, read by the falling-edge drivers.
  bit samp_fire = 1'b0;
  bit filt_fire = 1'b0;
  int fail_count = 0;

  function automatic longint coef_of(logic [CFG_BITS-1:0] r, int slot);
    logic [COEF_BITS-1:0] f;
    f = r[slot*COEF_BITS +: COEF_BITS];
    return longint'($signed(f));
  endfunction

  function automatic logic [CFG_BITS-1:0] pack_coefs(longint b0, longint a1, longint a2);
    logic [COEF_BITS-1:0] f0, f1, f2;
    f0 = b0[COEF_BITS-1:0];
    f1 = a1[COEF_BITS-1:0];
    f2 = a2[COEF_BITS-1:0];
    return CFG_BITS'({f2, f1, f0});
  endfunction

  // Butterworth sets for cutoffs of 0.1, 0.01 and 0.001 of the sample rate, in Q2.16.
  function automatic logic [CFG_BITS-1:0] butterworth_coefs(int k);
    case (k)
      0:       return pack_coefs(4421, -74906, 27053);
      1:       return pack_coefs(62, -125253, 59964);
      default: return pack_coefs(1, -130491, 64956);
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_coefs(int kind);
    case (kind)
      0:       return '0;
      1:       return '1;
      2:       return pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX);
      3:       return pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN);
      4:       return butterworth_coefs($urandom_range(0, 2));
      5:       return CFG_BITS'({$urandom(), $urandom()});
      default: return butterworth_coefs($urandom_range(0, 2)) ^ CFG_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  // Direct form I step in exact integer arithmetic: round half up, then saturate.
  function automatic filt_beat_t filter_step(samp_beat_t b);
    filt_beat_t r;
    longint x, b0, a1, a2, acc, y;
    int ch;
    ch = int'(b.channel);
    x  = longint'($signed(b.sample));
    b0 = 0;
    a1 = 0;
    a2 = 0;
    if (ch >= CHANNELS) begin
      y = x;
    end else if (b.prime) begin
      x_hist1[ch] = x;
      x_hist2[ch] = x;
      y_hist1[ch] = x;
      y_hist2[ch] = x;
      y = x;
    end else begin
      if (b.coef_set != COEF_SET_NONE) begin
        b0 = coef_of(coef_bank[b.coef_set], 0);
        a1 = coef_of(coef_bank[b.coef_set], 1);
        a2 = coef_of(coef_bank[b.coef_set], 2);
      end
      acc = b0 * (x + 2 * x_hist1[ch] + x_hist2[ch]) - a1 * y_hist1[ch] - a2 * y_hist2[ch];
      acc = acc + (longint'(1) << (FRAC - 1));
      y = acc >>> FRAC;
      if (y > SAMP_MAX) begin
        y = SAMP_MAX;
      end else if (y < SAMP_MIN) begin
        y = SAMP_MIN;
      end
      x_hist2[ch] = x_hist1[ch];
      x_hist1[ch] = x;
      y_hist2[ch] = y_hist1[ch];
      y_hist1[ch] = y;
    end
    r.out_channel = b.channel;
    r.filtered    = y[SAMPLE_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_BITS'(SAMP_MAX);
      1:       return SAMPLE_BITS'(SAMP_MIN);
      2, 3, 4: return SAMPLE_BITS'($urandom());
      default: return SAMPLE_BITS'(int'($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    // Every mismatch prints one line and counts.
    $display("%0t ns mismatch in %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic queue_sample(logic [CHANNEL_BITS-1:0] ch, logic [COEF_SET_BITS-1:0] set,
                              logic pr, logic signed [SAMPLE_BITS-1:0] s);
    samp_beat_t b;
    b.channel  = ch;
    b.coef_set = set;
    b.prime    = pr;
    b.sample   = s;
    pending_samp.push_back(b);
  endtask

  // Register writes are only issued while the block is idle, so the local copy can
  // change at the same moment.
  task automatic write_coef(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx != CFG_UNUSED) begin
      coef_bank[idx] = value;
    end
  endtask

  // Sample-side driver state.
  bit samp_busy = 1'b0;
  bit samp_calm = 1'b0;
  int samp_gap  = 0;

  task automatic drain();
    while (pending_samp.size() != 0 || samp_busy || pending_filt.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // Sample driver: after each accepted beat it idles for a drawn number of cycles,
  // with occasional stretches where it idles not at all. A beat held under stall
  // keeps its payload.
  always @(negedge clk) begin
    if (rst) begin
      samp_valid <= 1'b0;
    end else begin
      if (samp_fire) begin
        samp_busy = 1'b0;
        if ($urandom_range(0, 39) == 0) begin
          samp_calm = !samp_calm;
        end
        samp_gap = samp_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (!samp_busy) begin
        if (samp_gap > 0) begin
          samp_gap--;
        end else if (pending_samp.size() != 0) begin
          samp_data <= pending_samp.pop_front();
          samp_busy = 1'b1;
        end
      end
      samp_valid <= samp_busy;
    end
  end

  // Result sink: stalls for a drawn number of cycles after each accepted beat,
  // whether or not the block has a beat ready.
  bit filt_calm = 1'b0;
  int filt_hold = 0;

  always @(negedge clk) begin
    if (rst) begin
      filt_stall <= 1'b0;
    end else begin
      if (filt_fire) begin
        if ($urandom_range(0, 39) == 0) begin
          filt_calm = !filt_calm;
        end
        filt_hold = filt_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (filt_hold > 0) begin
        filt_stall <= 1'b1;
        filt_hold--;
      end else begin
        filt_stall <= 1'b0;
      end
    end
  end

  // Monitor: checks each filtered beat against the oldest prediction, predicts each
  // accepted sample beat, and ends the run if the handshakes go quiet for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin : monitor
    filt_beat_t want;
    samp_fire = !rst && samp_valid && !samp_stall;
    filt_fire = !rst && filt_valid && !filt_stall;
    if (filt_fire) begin
      if (pending_filt.size() == 0) begin
        report_mismatch("unrequested beat", longint'($signed(filt_data.filtered)), 0);
      end else begin
        want = pending_filt.pop_front();
        if (filt_data.out_channel !== want.out_channel) begin
          report_mismatch("out_channel", filt_data.out_channel, want.out_channel);
        end
        if (filt_data.filtered !== want.filtered) begin
          report_mismatch("filtered", longint'($signed(filt_data.filtered)),
                          longint'($signed(want.filtered)));
        end
      end
    end
    if (samp_fire) begin
      pending_filt.push_back(filter_step(samp_data));
    end
    if (rst || samp_fire || filt_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CHANNEL_BITS-1:0]  ch;
    logic [COEF_SET_BITS-1:0] set;
    logic                     pr;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // With the registers still at reset every filtered value is zero; a prime still
    // returns its sample.
    queue_sample(4'd0, COEF_SET_FAST, 1'b0, SAMPLE_BITS'(SAMP_MAX));
    queue_sample(4'd15, COEF_SET_VERY_SLOW, 1'b0, SAMPLE_BITS'(SAMP_MIN));
    queue_sample(4'd3, COEF_SET_NONE, 1'b1, SAMPLE_BITS'(SAMP_MAX));
    queue_sample(4'd3, COEF_SET_SLOW, 1'b0, '0);
    drain();

    write_coef(CFG_COEF_FAST, butterworth_coefs(0));
    write_coef(CFG_COEF_SLOW, pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX));
    write_coef(CFG_COEF_VERY_SLOW, pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN));
    write_coef(CFG_UNUSED, CFG_BITS'({$urandom(), $urandom()}));

    // Step response on one channel, back to back so the same-channel hazard is hit.
    queue_sample(4'd1, COEF_SET_FAST, 1'b1, 24'sd256);
    repeat (5) queue_sample(4'd1, COEF_SET_FAST, 1'b0, 24'sd256);
    // Coefficients at both extremes drive the output into the upper saturation limit.
    queue_sample(4'd2, COEF_SET_SLOW, 1'b0, SAMPLE_BITS'(SAMP_MAX));
    queue_sample(4'd2, COEF_SET_SLOW, 1'b0, SAMPLE_BITS'(SAMP_MAX));
    queue_sample(4'd4, COEF_SET_VERY_SLOW, 1'b0, SAMPLE_BITS'(SAMP_MIN));
    queue_sample(4'd4, COEF_SET_VERY_SLOW, 1'b0, SAMPLE_BITS'(SAMP_MAX));
    // The unused selector filters with zero coefficients but still moves the history.
    queue_sample(4'd5, COEF_SET_NONE, 1'b0, 24'sd12345);
    queue_sample(4'd5, COEF_SET_FAST, 1'b0, -24'sd1);
    // A prime ignores its selector.
    queue_sample(4'd6, COEF_SET_NONE, 1'b1, SAMPLE_BITS'(SAMP_MIN));
    queue_sample(4'd6, COEF_SET_FAST, 1'b0, '0);
    queue_sample(4'd15, COEF_SET_FAST, 1'b0, SAMPLE_BITS'(SAMP_MAX));
    queue_sample(4'd0, COEF_SET_SLOW, 1'b0, SAMPLE_BITS'(SAMP_MIN));
    queue_sample(4'd15, COEF_SET_VERY_SLOW, 1'b0, -24'sd1);
    queue_sample(4'd7, COEF_SET_FAST, 1'b0, 24'h555555);
    queue_sample(4'd7, COEF_SET_FAST, 1'b0, 24'hAAAAAA);
    drain();

    // Each phase rotates every register through zero, all ones, both extremes,
    // Butterworth sets, perturbed sets and random words.
    ch = '0;
    for (int p = 0; p < PHASES; p++) begin
      for (int r = 0; r < 3; r++) begin
        write_coef(CFG_INDEX_BITS'(r), pick_coefs((p * 3 + r) % 7));
      end
      for (int c = 0; c < CHANNELS; c++) begin
        queue_sample(CHANNEL_BITS'(c), COEF_SET_FAST, 1'b1, draw_sample());
      end
      for (int i = CHANNELS; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 2) != 0) begin
          ch = CHANNEL_BITS'($urandom_range(0, CHANNELS - 1));
        end
        pr  = ($urandom_range(0, 31) == 0);
        set = ($urandom_range(0, 15) == 0) ? COEF_SET_NONE
                                            : COEF_SET_BITS'($urandom_range(0, 2));
        queue_sample(ch, set, pr, draw_sample());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/bqlp_pkg.sv
src/bqlp_ram.sv
src/bqlp_mac.sv
src/biquad_lowpass_filter_bank.sv
tb/sv/tb_top.sv
